// ===== hw/rtl/p2a_pkg.sv =====
// shared types, constants and the arctangent table generator for the octant angle block
package p2a_pkg;

    localparam int unsigned INDEX_BITS_DEF = 11;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned REM_W          = DATA_W + 1;
    localparam int unsigned ROM_W          = 30;

    // 2^29 stands for an eighth of a turn
    localparam real ROM_SCALE = 2.0 ** 29;

    // reciprocal of atan(1), so each table entry scales by a product
    localparam real INV_EIGHTH = 1.0 / $atan(1.0);

    localparam logic [DATA_W-1:0] ANG_0      = 32'h0000_0000;
    localparam logic [DATA_W-1:0] ANG_90     = 32'h4000_0000;
    localparam logic [DATA_W-1:0] ANG_90_M1  = 32'h3FFF_FFFF;
    localparam logic [DATA_W-1:0] ANG_180    = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ANG_180_M1 = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ANG_270    = 32'hC000_0000;
    localparam logic [DATA_W-1:0] ANG_270_M1 = 32'hBFFF_FFFF;

    // octant flags that ride along with each beat
    typedef struct packed {
        logic zero;
        logic xneg;
        logic yneg;
        logic swap;
    } t_tag;

    // floor(2^29 * atan(idx / 2^bits) / atan(1)), evaluated at elaboration
    function automatic logic [ROM_W-1:0] atan_entry(input int unsigned idx,
                                                    input int unsigned bits);
        real ratio;
        real turn;
        if (idx >= (32'd1 << bits)) begin
            // atan(1) is exactly one eighth of a turn
            return ROM_W'(longint'(ROM_SCALE));
        end
        ratio = real'(idx) * $pow(2.0, -real'(bits));
        turn  = $atan(ratio) * INV_EIGHTH;
        return ROM_W'(longint'($floor(turn * ROM_SCALE)));
    endfunction

endpackage

// ===== hw/rtl/p2a_div_cell.sv =====
// one restoring-division cell: resolves one quotient bit per beat
module p2a_div_cell #(
    parameter int unsigned QUO_W = p2a_pkg::INDEX_BITS_DEF + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  p2a_pkg::t_tag              i_tag,
    input  logic [p2a_pkg::REM_W-1:0]  i_rem,
    input  logic [p2a_pkg::DATA_W-1:0] i_div,
    input  logic [QUO_W-1:0]           i_quo,
    output logic                       o_valid,
    output p2a_pkg::t_tag              o_tag,
    output logic [p2a_pkg::REM_W-1:0]  o_rem,
    output logic [p2a_pkg::DATA_W-1:0] o_div,
    output logic [QUO_W-1:0]           o_quo
);
    import p2a_pkg::*;

    logic              r_valid;
    t_tag              r_tag;
    logic [REM_W-1:0]  r_rem;
    logic [DATA_W-1:0] r_div;
    logic [QUO_W-1:0]  r_quo;

    logic              ge;
    logic [REM_W-1:0]  diff;
    logic [REM_W-1:0]  n_rem;

    always_comb begin
        ge    = (i_rem >= {1'b0, i_div});
        diff  = i_rem - {1'b0, i_div};
        // remainder stays below the divisor, so the shift never loses a bit
        n_rem = ge ? {diff[DATA_W-1:0], 1'b0} : {i_rem[DATA_W-1:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= i_tag;
        r_rem <= n_rem;
        r_div <= i_div;
        r_quo <= {i_quo[QUO_W-2:0], ge};
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;

endmodule

// ===== hw/rtl/p2a_rom.sv =====
// arctangent table with registered read, index saturated at the last entry
module p2a_rom #(
    parameter int unsigned INDEX_BITS = p2a_pkg::INDEX_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  p2a_pkg::t_tag             i_tag,
    input  logic [INDEX_BITS:0]       i_quo,
    output logic                      o_valid,
    output p2a_pkg::t_tag             o_tag,
    output logic [p2a_pkg::ROM_W-1:0] o_val
);
    import p2a_pkg::*;

    localparam int unsigned ROM_DEPTH = (1 << INDEX_BITS) + 1;
    localparam logic [INDEX_BITS:0] ROM_LAST = (INDEX_BITS + 1)'(1 << INDEX_BITS);

    typedef logic [ROM_W-1:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom tab;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            tab[i] = atan_entry(i, INDEX_BITS);
        end
        return tab;
    endfunction

    localparam t_rom ROM_TABLE = build_rom();

    logic [INDEX_BITS:0] addr;
    logic                r_valid;
    t_tag                r_tag;
    logic [ROM_W-1:0]    r_val;

    // top quotient bit only set for an exact tie (or the zero vector)
    assign addr = i_quo[INDEX_BITS] ? ROM_LAST : i_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= i_tag;
        r_val <= ROM_TABLE[addr];
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_val   = r_val;

endmodule

// ===== hw/rtl/point_to_angle_octant_top.sv =====
// top level: vector to 32-bit binary angle via octant fold, divider chain and table
//
// Takes a signed 16.16 vector on i_vec_x / i_vec_y and returns its direction on o_angle as
// an unsigned binary angle (2^32 per turn, zero along +x). A vector is taken on any rising
// edge with start high and busy low; busy is high only during reset and until the run flag
// is registered after it, so one vector can be sent every cycle. Each vector produces exactly
// one result, marked by o_valid for one cycle, in the order taken. The pipeline is a chain of
// INDEX_BITS + 1 division cells, each settling one bit of the table index, plus two front
// stages (magnitude, then octant compare), the table read and the final octant correction.
// There is no output backpressure: the receiver must take every result beat when shown.
module point_to_angle_octant_top #(
    parameter int unsigned INDEX_BITS = p2a_pkg::INDEX_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [p2a_pkg::DATA_W-1:0] i_vec_x,
    input  logic [p2a_pkg::DATA_W-1:0] i_vec_y,
    output logic                       o_valid,
    output logic [p2a_pkg::DATA_W-1:0] o_angle
);
    import p2a_pkg::*;

    localparam int unsigned QUO_W = INDEX_BITS + 1;

    // ---- run flag: ready for beats once out of reset
    logic r_run;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy   = ~r_run;
    assign accept = start & r_run;

    // ---- stage 1: signs and unsigned magnitudes (handles -2^31 cleanly)
    logic              r_s1_valid;
    t_tag              r_s1_tag;
    logic [DATA_W-1:0] r_mx;
    logic [DATA_W-1:0] r_my;
    t_tag              n_s1_tag;
    logic [DATA_W-1:0] n_mx;
    logic [DATA_W-1:0] n_my;

    always_comb begin
        n_s1_tag.zero = (i_vec_x == '0) && (i_vec_y == '0);
        n_s1_tag.xneg = i_vec_x[DATA_W-1];
        n_s1_tag.yneg = i_vec_y[DATA_W-1];
        n_s1_tag.swap = 1'b0;
        n_mx = i_vec_x[DATA_W-1] ? (DATA_W'(0) - i_vec_x) : i_vec_x;
        n_my = i_vec_y[DATA_W-1] ? (DATA_W'(0) - i_vec_y) : i_vec_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag <= n_s1_tag;
        r_mx     <= n_mx;
        r_my     <= n_my;
    end

    // ---- stage 2: strict compare picks the octant half, ties go to "y larger"
    logic              r_s2_valid;
    t_tag              r_s2_tag;
    logic [DATA_W-1:0] r_small;
    logic [DATA_W-1:0] r_large;
    logic              swap;
    t_tag              n_s2_tag;

    always_comb begin
        swap          = ~(r_mx > r_my);
        n_s2_tag      = r_s1_tag;
        n_s2_tag.swap = swap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_tag <= n_s2_tag;
        r_small  <= swap ? r_mx : r_my;
        r_large  <= swap ? r_my : r_mx;
    end

    // ---- divider chain: index = floor(small * 2^INDEX_BITS / large), one bit per cell
    logic              c_valid [QUO_W+1];
    t_tag              c_tag   [QUO_W+1];
    logic [REM_W-1:0]  c_rem   [QUO_W+1];
    logic [DATA_W-1:0] c_div   [QUO_W+1];
    logic [QUO_W-1:0]  c_quo   [QUO_W+1];

    assign c_valid[0] = r_s2_valid;
    assign c_tag[0]   = r_s2_tag;
    assign c_rem[0]   = {1'b0, r_small};
    assign c_div[0]   = r_large;
    assign c_quo[0]   = '0;

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        p2a_div_cell #(
            .QUO_W (QUO_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_tag   (c_tag[k]),
            .i_rem   (c_rem[k]),
            .i_div   (c_div[k]),
            .i_quo   (c_quo[k]),
            .o_valid (c_valid[k+1]),
            .o_tag   (c_tag[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_div   (c_div[k+1]),
            .o_quo   (c_quo[k+1])
        );
    end

    // ---- table read
    logic             rom_valid;
    t_tag             rom_tag;
    logic [ROM_W-1:0] rom_val;

    p2a_rom #(
        .INDEX_BITS (INDEX_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[QUO_W]),
        .i_tag   (c_tag[QUO_W]),
        .i_quo   (c_quo[QUO_W]),
        .o_valid (rom_valid),
        .o_tag   (rom_tag),
        .o_val   (rom_val)
    );

    // ---- octant correction: base +/- table value, zero vector forced to 0
    logic              r_out_valid;
    logic [DATA_W-1:0] r_angle;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] t_ext;
    logic              sub;
    logic [DATA_W-1:0] n_angle;

    always_comb begin
        t_ext = {{(DATA_W - ROM_W){1'b0}}, rom_val};
        sub   = rom_tag.xneg ^ rom_tag.yneg ^ rom_tag.swap;
        if (!rom_tag.xneg) begin
            if (!rom_tag.yneg) begin
                base = rom_tag.swap ? ANG_90_M1 : ANG_0;
            end else begin
                base = rom_tag.swap ? ANG_270 : ANG_0;
            end
        end else begin
            if (!rom_tag.yneg) begin
                base = rom_tag.swap ? ANG_90 : ANG_180_M1;
            end else begin
                base = rom_tag.swap ? ANG_270_M1 : ANG_180;
            end
        end
        if (rom_tag.zero) begin
            n_angle = ANG_0;
        end else if (sub) begin
            n_angle = base - t_ext;
        end else begin
            n_angle = base + t_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= rom_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
    end

    assign o_valid = r_out_valid;
    assign o_angle = r_angle;

endmodule

// ===== hw/rtl/p2a_chk.sv =====
// port-level checker for the octant angle block, bound to the top level
module p2a_chk #(
    parameter int unsigned INDEX_BITS = p2a_pkg::INDEX_BITS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [p2a_pkg::DATA_W-1:0] i_vec_x,
    input logic [p2a_pkg::DATA_W-1:0] i_vec_y,
    input logic                       o_valid,
    input logic [p2a_pkg::DATA_W-1:0] o_angle
);
    import p2a_pkg::*;

    localparam int unsigned LATENCY = INDEX_BITS + 5;

    logic accept;
    assign accept = start && !busy;

    // every result beat traces back to exactly one accepted beat
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result beat without a matching input beat");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("input beat produced no result beat");

    // zero vector maps to angle zero
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_vec_x == '0 && i_vec_y == '0) |-> ##LATENCY (o_angle == ANG_0))
        else $error("zero vector did not give angle zero");

    // equal positive components take the y-larger branch: just under 45 degrees
    a_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_vec_x == i_vec_y && !i_vec_x[DATA_W-1] && i_vec_x != '0)
        |-> ##LATENCY (o_angle == 32'h1FFF_FFFF))
        else $error("first diagonal gave the wrong angle");

endmodule

bind point_to_angle_octant_top p2a_chk #(.INDEX_BITS(INDEX_BITS)) u_p2a_chk (.*);

// ===== verif/angle_checker.sv =====
`timescale 1ns / 1ps
// checker: predicts the binary angle of every accepted vector and compares each result beat
module angle_checker #(
    parameter int unsigned INDEX_BITS = p2a_pkg::INDEX_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [p2a_pkg::DATA_W-1:0] i_vec_x,
    input  logic [p2a_pkg::DATA_W-1:0] i_vec_y,
    input  logic                       i_valid,
    input  logic [p2a_pkg::DATA_W-1:0] i_angle,
    output int                         o_fail_count,
    output int                         o_pending
);
    import p2a_pkg::*;

    localparam int unsigned     TAB_TOP  = 1 << INDEX_BITS;
    localparam logic [63:0]     Q62_UNIT = 64'd1 << 62;

    typedef struct {
        logic [DATA_W-1:0] vec_x;
        logic [DATA_W-1:0] vec_y;
        logic [DATA_W-1:0] angle;
    } t_angle_due;

    t_angle_due       angle_due_q[$];
    logic [ROM_W-1:0] atan_rom [0:TAB_TOP];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    // floor(a * m / d) with no intermediate overflow
    function automatic logic [63:0] frac_floor(input logic [63:0] a, input logic [63:0] m,
                                               input logic [63:0] d);
        logic [127:0] wide;
        wide = ({64'd0, a} * {64'd0, m}) / {64'd0, d};
        return wide[63:0];
    endfunction

    // atan(p/q) in q62 by the euler series, p <= q, q >= 1
    function automatic logic [63:0] euler_atan(input logic [63:0] p, input logic [63:0] q);
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] total;
        int          n;
        s     = p * p + q * q;
        term  = frac_floor(Q62_UNIT, p * q, s);
        total = '0;
        for (n = 0; n < 80 && term != 0; n++) begin
            total += term;
            term   = frac_floor(term, p * p, s);
            term   = frac_floor(term, 64'(2 * n + 2), 64'(2 * n + 3));
        end
        return total;
    endfunction

    // entry i = floor(2^29 * atan(i / 2^bits) / atan(1))
    initial begin : build_atan_rom
        logic [63:0]  eighth;
        logic [127:0] scaled;
        int           i;
        eighth = euler_atan(64'(TAB_TOP), 64'(TAB_TOP));
        for (i = 0; i <= TAB_TOP; i++) begin
            scaled      = ({64'd0, euler_atan(64'(i), 64'(TAB_TOP))} << 29) / {64'd0, eighth};
            atan_rom[i] = scaled[ROM_W-1:0];
        end
    end

    function automatic logic [DATA_W-1:0] table_angle(input logic [DATA_W-1:0] minor,
                                                      input logic [DATA_W-1:0] major);
        logic [63:0] idx;
        idx = '0;
        if (major != 0) begin
            idx = ({32'd0, minor} << INDEX_BITS) / {32'd0, major};
        end
        if (idx > TAB_TOP) begin
            idx = TAB_TOP;
        end
        return DATA_W'(atan_rom[idx]);
    endfunction

    function automatic logic [DATA_W-1:0] vector_angle(input logic [DATA_W-1:0] vx,
                                                       input logic [DATA_W-1:0] vy);
        logic [DATA_W-1:0] mx;
        logic [DATA_W-1:0] my;
        logic              x_major;
        logic [DATA_W-1:0] ang;
        mx      = vx[DATA_W-1] ? -vx : vx;
        my      = vy[DATA_W-1] ? -vy : vy;
        x_major = mx > my;
        if (vx == 0 && vy == 0) begin
            ang = ANG_0;
        end else begin
            case ({vx[DATA_W-1], vy[DATA_W-1]})
                2'b00: begin
                    ang = x_major ? table_angle(my, mx) : ANG_90_M1 - table_angle(mx, my);
                end
                2'b01: begin
                    ang = x_major ? ANG_0 - table_angle(my, mx) : ANG_270 + table_angle(mx, my);
                end
                2'b10: begin
                    ang = x_major ? ANG_180_M1 - table_angle(my, mx)
                                  : ANG_90 + table_angle(mx, my);
                end
                default: begin
                    ang = x_major ? ANG_180 + table_angle(my, mx)
                                  : ANG_270_M1 - table_angle(mx, my);
                end
            endcase
        end
        return ang;
    endfunction

    always @(posedge i_clk) begin : watch_beats
        t_angle_due due;
        logic       have_due;
        if (!i_rst_n) begin
            o_pending <= 0;
        end else begin
            // result side first so a result can never match a vector taken on the same edge
            if (i_valid) begin
                have_due = angle_due_q.size() != 0;
                if (have_due) begin
                    due = angle_due_q.pop_front();
                end
                if (!have_due || due.angle !== i_angle) begin
                    if (mismatches < 10) begin
                        if (have_due) begin
                            $display("angle error: x=%h y=%h expected %h got %h",
                                     due.vec_x, due.vec_y, due.angle, i_angle);
                        end else begin
                            $display("angle error: result %h with no vector outstanding",
                                     i_angle);
                        end
                    end
                    mismatches++;
                end
            end
            if (i_start && !i_busy) begin
                angle_due_q.push_back('{i_vec_x, i_vec_y, vector_angle(i_vec_x, i_vec_y)});
            end
            o_pending <= angle_due_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench top: drives vectors into the octant angle block and reports the verdict
module testbench;
    import p2a_pkg::*;

    localparam int unsigned INDEX_BITS     = INDEX_BITS_DEF;
    // delay from a taken vector to its result beat
    localparam int          LATENCY        = INDEX_BITS + 5;
    // cycles with neither a vector nor a result taken before the run is called dead
    localparam int          STALL_LIMIT    = 1000;
    localparam int          RANDOM_VECTORS = 650;
    localparam int          CORNER_VECTORS = 23;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    logic [DATA_W-1:0] i_vec_x = '0;
    logic [DATA_W-1:0] i_vec_y = '0;
    logic              o_valid;
    logic [DATA_W-1:0] o_angle;

    int fail_count;
    int pending_count;
    int stall_cycles = 0;
    // sender inserts random gaps only while this is set
    bit gaps_on      = 1'b1;

    always #1 i_clk = ~i_clk;

    point_to_angle_octant_top #(
        .INDEX_BITS (INDEX_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .o_valid (o_valid),
        .o_angle (o_angle)
    );

    angle_checker #(
        .INDEX_BITS (INDEX_BITS)
    ) u_angle_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_valid      (o_valid),
        .i_angle      (o_angle),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // watchdog: any beat in either direction restarts the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("point_to_angle_octant_top: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one vector beat: optional random gap, then hold start until busy is low at an edge
    task automatic send_vector(input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy);
        while (gaps_on && $urandom_range(0, 99) < 34) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_vec_x <= vx;
        i_vec_y <= vy;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [DATA_W-1:0] vx;
        logic [DATA_W-1:0] vy;
        logic [DATA_W-1:0] big;
        logic [DATA_W-1:0] little;
        logic [DATA_W-1:0] held;
        int                mode;
        int                k;

        // synchronous reset, held low from time zero and then released
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: zero vector, the axes, ties in every quadrant, the most
        // negative value, index zero and the last index, and both branches of each quadrant
        for (k = 0; k < CORNER_VECTORS; k++) begin
            case (k)
                0:       {vx, vy} = {32'h0000_0000, 32'h0000_0000};
                1:       {vx, vy} = {32'h0000_0001, 32'h0000_0000};
                2:       {vx, vy} = {32'h0000_0000, 32'h0000_0001};
                3:       {vx, vy} = {32'hFFFF_FFFF, 32'h0000_0000};
                4:       {vx, vy} = {32'h0000_0000, 32'hFFFF_FFFF};
                5:       {vx, vy} = {32'h0001_0000, 32'h0001_0000};
                6:       {vx, vy} = {32'hFFFF_0000, 32'h0001_0000};
                7:       {vx, vy} = {32'hFFFF_0000, 32'hFFFF_0000};
                8:       {vx, vy} = {32'h0001_0000, 32'hFFFF_0000};
                9:       {vx, vy} = {32'h8000_0000, 32'h8000_0000};
                10:      {vx, vy} = {32'h8000_0000, 32'h0000_0000};
                11:      {vx, vy} = {32'h0000_0000, 32'h8000_0000};
                12:      {vx, vy} = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
                13:      {vx, vy} = {32'h7FFF_FFFF, 32'h8000_0000};
                14:      {vx, vy} = {32'h8000_0000, 32'h7FFF_FFFF};
                15:      {vx, vy} = {32'h7FFF_FFFF, 32'h0000_0001};
                16:      {vx, vy} = {32'h0000_0001, 32'h7FFF_FFFF};
                17:      {vx, vy} = {32'h7FFF_FFFF, 32'h7FFF_FFFE};
                18:      {vx, vy} = {32'h8000_0000, 32'h8000_0001};
                19:      {vx, vy} = {32'hFFFF_FFFF, 32'h7FFF_FFFF};
                20:      {vx, vy} = {32'h0003_0000, 32'hFFFD_0001};
                21:      {vx, vy} = {32'hFFFF_FFFF, 32'hFFFF_FFFE};
                default: {vx, vy} = {32'h1234_5678, 32'h9ABC_DEF0};
            endcase
            send_vector(vx, vy);
        end

        for (k = 0; k < RANDOM_VECTORS; k++) begin
            // back-to-back stretch with the sender never pausing
            gaps_on = !(k >= 150 && k < 300);

            // hold off once until the pipeline has fully drained
            if (k == 400) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_count != 0) begin
                    @(posedge i_clk);
                end
            end

            mode = $urandom_range(0, 99);
            if (mode < 35) begin
                // full-range raw words, every bit of both fields toggles
                vx = $urandom;
                vy = $urandom;
            end else if (mode < 50) begin
                // tiny vectors around the origin, zero vector included
                vx = DATA_W'($urandom_range(0, 32)) - 32'd16;
                vy = DATA_W'($urandom_range(0, 32)) - 32'd16;
            end else begin
                // built from magnitudes: ties, near ties, ratio sweep, on an axis
                big = $urandom_range(32'h7FFF_FFFF, 1);
                if ($urandom_range(0, 7) == 0) begin
                    big = 32'h8000_0000;
                end
                if (mode < 65) begin
                    little = big;
                end else if (mode < 80) begin
                    little = (big > 3) ? big - DATA_W'($urandom_range(0, 3)) : big;
                end else if (mode < 90) begin
                    little = big >> $urandom_range(0, 31);
                end else begin
                    little = '0;
                end
                if ($urandom_range(0, 1) == 1) begin
                    held   = big;
                    big    = little;
                    little = held;
                end
                vx = $urandom_range(0, 1) ? -big : big;
                vy = $urandom_range(0, 1) ? -little : little;
            end
            send_vector(vx, vy);
        end

        start <= 1'b0;
        @(posedge i_clk);
        // the watchdog bounds this wait
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        // catch any stray result beat behind the last expected one
        repeat (LATENCY + 8) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("point_to_angle_octant_top: match");
        end else begin
            $display("point_to_angle_octant_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/p2a_pkg.sv
hw/rtl/p2a_div_cell.sv
hw/rtl/p2a_rom.sv
hw/rtl/point_to_angle_octant_top.sv
hw/rtl/p2a_chk.sv
verif/angle_checker.sv
verif/testbench.sv
